// ----- design/signed_power_waveshaper_macros.svh -----
// Assertion macros used by the checker file of the signed power waveshaper.
// No dependencies; the clock, the reset and the message are macro arguments.
`ifndef SIGNED_POWER_WAVESHAPER_MACROS_SVH
`define SIGNED_POWER_WAVESHAPER_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define SPW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define SPW_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define SPW_ASSERT_ALWAYS_NXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/spw_pkg.sv -----
// Shared constants, types and constant tables of the signed power waveshaper.
// Depends on nothing; every design module refers to it by scoped names.
`default_nettype none

package spw_pkg;

    localparam int SAMPLE_WIDTH     = 16;
    localparam int TABLE_INDEX_BITS = 8;

    localparam int DRIVE_W  = 16;
    localparam int EXPO_W   = 16;
    localparam int OUT_W    = 20;

    // Magnitude times drive, and the position of the leading one in it.
    localparam int M_W      = SAMPLE_WIDTH + DRIVE_W;
    localparam int P_W      = $clog2(M_W);
    localparam int ONE_POS  = SAMPLE_WIDTH + 11;
    localparam int NORM_W   = (M_W > 31) ? M_W : 31;
    localparam int SH_W     = $clog2(NORM_W);
    localparam int FRAC_W   = 30;
    localparam int LREM_W   = FRAC_W - TABLE_INDEX_BITS;

    localparam int TSIZE    = (1 << TABLE_INDEX_BITS) + 1;
    localparam int TI_W     = TABLE_INDEX_BITS + 1;
    localparam int LOG_W    = 17;
    localparam int LG_W     = P_W + 18;

    localparam int E_W      = EXPO_W + 1;
    localparam int PR_W     = LG_W + E_W;
    localparam int N_W      = PR_W - 31;
    localparam int EF_W     = 16;
    localparam int EREM_W   = EF_W - TABLE_INDEX_BITS;
    localparam int EXP_W    = 32;

    localparam int MAX_SH   = 40;
    localparam int RSH_W    = $clog2(MAX_SH + 1);
    localparam int RND_W    = MAX_SH + 1;
    localparam int OUT_MAX  = (1 << (OUT_W - 1)) - 1;
    localparam int OUT_ONE  = 15;

    localparam logic [EXPO_W-1:0] EXP_FLOOR = EXPO_W'(328);

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_GAIN     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SHAPE_EXPONENT = CFG_IDX_W'(1);
    localparam logic [DRIVE_W-1:0]   DRIVE_RESET        = DRIVE_W'(4096);
    localparam logic [EXPO_W-1:0]    EXPO_RESET         = EXPO_W'(0);

    typedef logic [LOG_W-1:0] t_log_tab [TSIZE];
    typedef logic [EXP_W-1:0] t_exp_tab [TSIZE];

    // Sign of the sample and whether the gained magnitude is zero.
    typedef struct packed {
        logic neg;
        logic zero;
    } t_side;

    function automatic longint unsigned isqrt64(longint unsigned v_in);
        longint unsigned v;
        longint unsigned res;
        longint unsigned bt;
        v   = v_in;
        res = 0;
        bt  = 64'd1 << 62;
        while (bt > v) bt = bt >> 2;
        while (bt != 0) begin
            if (v >= res + bt) begin
                v   = v - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    // log2(1 + i/2^T) in 16 fraction bits, found one result bit per squaring.
    function automatic t_log_tab build_log_tab();
        t_log_tab        tab;
        longint unsigned y;
        longint unsigned r;
        int              i;
        int              k;
        for (i = 0; i < TSIZE - 1; i++) begin
            y = 64'((1 << TABLE_INDEX_BITS) + i) << (FRAC_W - TABLE_INDEX_BITS);
            r = 0;
            for (k = 0; k < 17; k++) begin
                y = (y * y) >> 30;
                r = r << 1;
                if (y >= (64'd1 << 31)) begin
                    r = r | 64'd1;
                    y = y >> 1;
                end
            end
            tab[i] = LOG_W'((r + 64'd1) >> 1);
        end
        tab[TSIZE-1] = LOG_W'(65536);
        return tab;
    endfunction

    // 2^(i/2^T) in Q2.30, built from a chain of square roots of two.
    function automatic t_exp_tab build_exp_tab();
        t_exp_tab        tab;
        longint unsigned roots [TABLE_INDEX_BITS+1];
        longint unsigned e;
        int              i;
        int              k;
        roots[0] = 64'd1 << 31;
        for (k = 1; k <= TABLE_INDEX_BITS; k++) begin
            roots[k] = isqrt64(roots[k-1] << 30);
        end
        for (i = 0; i < TSIZE - 1; i++) begin
            e = 64'd1 << 30;
            for (k = 0; k < TABLE_INDEX_BITS; k++) begin
                if (((i >> k) & 1) != 0) begin
                    e = (e * roots[TABLE_INDEX_BITS-k] + (64'd1 << 29)) >> 30;
                end
            end
            tab[i] = EXP_W'(e);
        end
        tab[TSIZE-1] = EXP_W'(64'd1 << 31);
        return tab;
    endfunction

    localparam t_log_tab LOG_TAB = build_log_tab();
    localparam t_exp_tab EXP_TAB = build_exp_tab();

endpackage

`default_nettype wire

// ----- design/spw_log.sv -----
// Log2 pipeline: gain multiply, leading-one search, normalize, table, interpolate.
// Uses spw_pkg for widths, the side-band struct and the log2 table.
`default_nettype none

module spw_log (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic [spw_pkg::SAMPLE_WIDTH-1:0]   i_mag,
    input  wire logic                               i_neg,
    input  wire logic [spw_pkg::DRIVE_W-1:0]        i_drive,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic signed [spw_pkg::LG_W-1:0]         o_lg,
    output spw_pkg::t_side                          o_side
);

    localparam int NL = 6;
    localparam int T  = spw_pkg::TABLE_INDEX_BITS;
    localparam int IPR_W = spw_pkg::LOG_W + spw_pkg::LREM_W;

    logic [NL-1:0] r_v;
    logic [NL-1:0] w_go;

    // Stage 0: gain product.
    logic [spw_pkg::M_W-1:0]    r_m_a;
    logic                       r_neg_a;
    // Stage 1: leading-one position.
    logic [spw_pkg::M_W-1:0]    r_m_b;
    logic [spw_pkg::P_W-1:0]    r_p_b;
    spw_pkg::t_side             r_side_b;
    // Stage 2: table index and remainder.
    logic [T-1:0]               r_idx_c;
    logic [spw_pkg::LREM_W-1:0] r_rem_c;
    logic [spw_pkg::P_W-1:0]    r_p_c;
    spw_pkg::t_side             r_side_c;
    // Stage 3: table entries.
    logic [spw_pkg::LOG_W-1:0]  r_l0_d;
    logic [spw_pkg::LOG_W-1:0]  r_l1_d;
    logic [spw_pkg::LREM_W-1:0] r_rem_d;
    logic [spw_pkg::P_W-1:0]    r_p_d;
    spw_pkg::t_side             r_side_d;
    // Stage 4: interpolation term.
    logic [spw_pkg::LOG_W-1:0]  r_l0_e;
    logic [spw_pkg::LOG_W-1:0]  r_ip_e;
    logic [spw_pkg::P_W-1:0]    r_p_e;
    spw_pkg::t_side             r_side_e;
    // Stage 5: log2 value.
    logic signed [spw_pkg::LG_W-1:0] r_lg;
    spw_pkg::t_side             r_side_f;

    logic [spw_pkg::P_W-1:0]    w_p;
    logic [spw_pkg::SH_W-1:0]   w_lsh;
    logic [spw_pkg::NORM_W-1:0] w_norm;
    logic [spw_pkg::FRAC_W-1:0] w_frac;
    logic [spw_pkg::TI_W-1:0]   w_ti;
    logic [spw_pkg::LOG_W-1:0]  w_diff;
    logic [IPR_W-1:0]           w_iprod;
    logic signed [spw_pkg::P_W:0]    w_ipart;
    logic signed [spw_pkg::LG_W-1:0] w_lg;

    // A stage takes new data when it is empty or its contents move on.
    always_comb begin
        w_go[NL-1] = !r_v[NL-1] || i_ready;
        for (int k = NL - 2; k >= 0; k--) begin
            w_go[k] = !r_v[k] || w_go[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_go[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NL; k++) begin
                if (w_go[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    always_comb begin
        w_p = '0;
        for (int k = 0; k < spw_pkg::M_W; k++) begin
            if (r_m_a[k]) w_p = spw_pkg::P_W'(k);
        end
    end

    assign w_lsh  = spw_pkg::SH_W'(spw_pkg::NORM_W - 1) - spw_pkg::SH_W'(r_p_b);
    assign w_norm = spw_pkg::NORM_W'(r_m_b) << w_lsh;
    assign w_frac = w_norm[spw_pkg::NORM_W-2 -: spw_pkg::FRAC_W];
    assign w_ti   = {1'b0, r_idx_c};

    assign w_diff  = r_l1_d - r_l0_d;
    assign w_iprod = IPR_W'(w_diff) * IPR_W'(r_rem_d);

    assign w_ipart = $signed({1'b0, r_p_e}) - $signed((spw_pkg::P_W + 1)'(spw_pkg::ONE_POS));
    assign w_lg    = $signed({{(spw_pkg::LG_W - spw_pkg::P_W - 17){w_ipart[spw_pkg::P_W]}},
                              w_ipart, 16'h0000})
                   + $signed(spw_pkg::LG_W'(r_l0_e))
                   + $signed(spw_pkg::LG_W'(r_ip_e));

    always_ff @(posedge i_clk) begin
        if (w_go[0]) begin
            r_m_a   <= spw_pkg::M_W'(i_mag) * spw_pkg::M_W'(i_drive);
            r_neg_a <= i_neg;
        end
        if (w_go[1]) begin
            r_m_b         <= r_m_a;
            r_p_b         <= w_p;
            r_side_b.neg  <= r_neg_a;
            r_side_b.zero <= (r_m_a == '0);
        end
        if (w_go[2]) begin
            r_idx_c  <= w_frac[spw_pkg::FRAC_W-1 -: T];
            r_rem_c  <= w_frac[spw_pkg::LREM_W-1:0];
            r_p_c    <= r_p_b;
            r_side_c <= r_side_b;
        end
        if (w_go[3]) begin
            r_l0_d   <= spw_pkg::LOG_TAB[w_ti];
            r_l1_d   <= spw_pkg::LOG_TAB[w_ti + spw_pkg::TI_W'(1)];
            r_rem_d  <= r_rem_c;
            r_p_d    <= r_p_c;
            r_side_d <= r_side_c;
        end
        if (w_go[4]) begin
            r_l0_e   <= r_l0_d;
            r_ip_e   <= w_iprod[IPR_W-1:spw_pkg::LREM_W];
            r_p_e    <= r_p_d;
            r_side_e <= r_side_d;
        end
        if (w_go[5]) begin
            r_lg     <= w_lg;
            r_side_f <= r_side_e;
        end
    end

    assign o_ready = w_go[0];
    assign o_valid = r_v[NL-1];
    assign o_lg    = r_lg;
    assign o_side  = r_side_f;

endmodule

`default_nettype wire

// ----- design/spw_exp.sv -----
// Exp2 pipeline: exponent scale, table, interpolate, round to Q5.15, sign.
// Uses spw_pkg for widths, the side-band struct and the exp2 table.
`default_nettype none

module spw_exp (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic signed [spw_pkg::LG_W-1:0]    i_lg,
    input  wire spw_pkg::t_side                     i_side,
    input  wire logic [spw_pkg::EXPO_W-1:0]         i_expo,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic signed [spw_pkg::OUT_W-1:0]        o_sample
);

    localparam int NE = 5;
    localparam int T  = spw_pkg::TABLE_INDEX_BITS;
    localparam int EPR_W = spw_pkg::EXP_W + spw_pkg::EREM_W;

    logic [NE-1:0] r_v;
    logic [NE-1:0] w_go;

    // Stage 0: exponent times log2.
    logic signed [spw_pkg::PR_W-1:0] r_prod_a;
    spw_pkg::t_side             r_side_a;
    // Stage 1: table entries.
    logic [spw_pkg::EXP_W-1:0]  r_e0_b;
    logic [spw_pkg::EXP_W-1:0]  r_e1_b;
    logic [spw_pkg::EREM_W-1:0] r_rem_b;
    logic signed [spw_pkg::N_W-1:0] r_n_b;
    spw_pkg::t_side             r_side_b;
    // Stage 2: interpolation term.
    logic [spw_pkg::EXP_W-1:0]  r_e0_c;
    logic [spw_pkg::EXP_W-1:0]  r_ip_c;
    logic signed [spw_pkg::N_W-1:0] r_n_c;
    spw_pkg::t_side             r_side_c;
    // Stage 3: mantissa and shift decision.
    logic [spw_pkg::EXP_W-1:0]  r_g_d;
    logic [spw_pkg::RSH_W-1:0]  r_sh_d;
    logic                       r_sat_d;
    logic                       r_under_d;
    spw_pkg::t_side             r_side_d;
    // Stage 4: result.
    logic signed [spw_pkg::OUT_W-1:0] r_out;

    logic [spw_pkg::EXPO_W-1:0]       w_expo;
    logic signed [spw_pkg::PR_W-1:0]  w_prod;
    logic [spw_pkg::EF_W-1:0]         w_f;
    logic [spw_pkg::TI_W-1:0]         w_ti;
    logic [spw_pkg::EXP_W-1:0]        w_diff;
    logic [EPR_W-1:0]                 w_eprod;
    logic signed [spw_pkg::N_W:0]     w_sh;
    logic [spw_pkg::RND_W-1:0]        w_rnd;
    logic [spw_pkg::RND_W-1:0]        w_q;
    logic [spw_pkg::OUT_W-1:0]        w_mag;

    always_comb begin
        w_go[NE-1] = !r_v[NE-1] || i_ready;
        for (int k = NE - 2; k >= 0; k--) begin
            w_go[k] = !r_v[k] || w_go[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_go[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NE; k++) begin
                if (w_go[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // A zero exponent register stands for about 0.01.
    assign w_expo = (i_expo == '0) ? spw_pkg::EXP_FLOOR : i_expo;
    assign w_prod = spw_pkg::PR_W'(i_lg) * $signed(spw_pkg::PR_W'(w_expo));

    // The product floored to 16 fraction bits splits into integer and fraction.
    assign w_f  = r_prod_a[30:15];
    assign w_ti = {1'b0, w_f[spw_pkg::EF_W-1 -: T]};

    assign w_diff  = r_e1_b - r_e0_b;
    assign w_eprod = EPR_W'(w_diff) * EPR_W'(r_rem_b);

    assign w_sh = $signed((spw_pkg::N_W + 1)'(spw_pkg::OUT_ONE))
                - $signed((spw_pkg::N_W + 1)'(r_n_c));

    assign w_rnd = spw_pkg::RND_W'(r_g_d)
                 + (spw_pkg::RND_W'(1) << (r_sh_d - spw_pkg::RSH_W'(1)));
    assign w_q   = w_rnd >> r_sh_d;

    always_comb begin
        if (r_side_d.zero || r_under_d) begin
            w_mag = '0;
        end else if (r_sat_d || (w_q > spw_pkg::RND_W'(spw_pkg::OUT_MAX))) begin
            w_mag = spw_pkg::OUT_W'(spw_pkg::OUT_MAX);
        end else begin
            w_mag = w_q[spw_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go[0]) begin
            r_prod_a <= w_prod;
            r_side_a <= i_side;
        end
        if (w_go[1]) begin
            r_e0_b   <= spw_pkg::EXP_TAB[w_ti];
            r_e1_b   <= spw_pkg::EXP_TAB[w_ti + spw_pkg::TI_W'(1)];
            r_rem_b  <= w_f[spw_pkg::EREM_W-1:0];
            r_n_b    <= r_prod_a[spw_pkg::PR_W-1:31];
            r_side_b <= r_side_a;
        end
        if (w_go[2]) begin
            r_e0_c   <= r_e0_b;
            r_ip_c   <= w_eprod[EPR_W-1:spw_pkg::EREM_W];
            r_n_c    <= r_n_b;
            r_side_c <= r_side_b;
        end
        if (w_go[3]) begin
            r_g_d     <= r_e0_c + r_ip_c;
            r_sat_d   <= (r_n_c >= $signed(spw_pkg::N_W'(spw_pkg::OUT_ONE)));
            r_under_d <= (w_sh > $signed((spw_pkg::N_W + 1)'(spw_pkg::MAX_SH)));
            r_sh_d    <= spw_pkg::RSH_W'(w_sh);
            r_side_d  <= r_side_c;
        end
        if (w_go[4]) begin
            r_out <= r_side_d.neg ? $signed(-w_mag) : $signed(w_mag);
        end
    end

    assign o_ready  = w_go[0];
    assign o_valid  = r_v[NE-1];
    assign o_sample = r_out;

endmodule

`default_nettype wire

// ----- design/signed_power_waveshaper.sv -----
// Top level of the signed power waveshaper: input stage, registers, two pipelines.
// Depends on spw_pkg, spw_log and spw_exp.
`default_nettype none

// Signed power-law waveshaper. Each Q1.15 sample is scaled by drive_gain
// (Q4.12), its magnitude is raised to shape_exponent (Q1.15, zero acts as
// about 0.01) through log2 and exp2 tables with interpolation, and the sign
// is put back; the Q5.15 result saturates at +/-524287. The block is a
// twelve-stage pipeline (one input stage, six log2 stages, five exp2 stages)
// and takes one sample in every cycle while the output is not stalled.
// Stalls from the output propagate back only as far as the pipeline is
// full, so bubbles are squeezed out. Write the registers only while the
// pipeline is empty; config writes are always ready and take effect at
// the next cycle.
module signed_power_waveshaper (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_stall,
    input  wire logic signed [spw_pkg::SAMPLE_WIDTH-1:0] i_sample_in,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_stall,
    output logic signed [spw_pkg::OUT_W-1:0]            o_sample_out,
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [spw_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  wire logic [spw_pkg::CFG_DAT_W-1:0]          i_cfg_data
);

    localparam int SW = spw_pkg::SAMPLE_WIDTH;

    logic [spw_pkg::DRIVE_W-1:0] r_drive_gain;
    logic [spw_pkg::EXPO_W-1:0]  r_shape_exponent;

    logic          r_v0;
    logic [SW-1:0] r_mag0;
    logic          r_neg0;
    logic          w_go0;
    logic          w_neg;
    logic [SW-1:0] w_mag;

    logic                            w_log_ready;
    logic                            w_log_valid;
    logic signed [spw_pkg::LG_W-1:0] w_lg;
    spw_pkg::t_side                  w_side;
    logic                            w_exp_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive_gain     <= spw_pkg::DRIVE_RESET;
            r_shape_exponent <= spw_pkg::EXPO_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                spw_pkg::REG_DRIVE_GAIN: begin
                    r_drive_gain <= spw_pkg::DRIVE_W'(i_cfg_data);
                end
                spw_pkg::REG_SHAPE_EXPONENT: begin
                    r_shape_exponent <= spw_pkg::EXPO_W'(i_cfg_data);
                end
                default: begin
                end
            endcase
        end
    end

    // The most negative sample has magnitude 2^(SW-1), which still fits unsigned.
    assign w_neg = i_sample_in[SW-1];
    assign w_mag = w_neg ? (~i_sample_in + SW'(1)) : i_sample_in;

    assign w_go0      = !r_v0 || w_log_ready;
    assign o_in_stall = !w_go0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_go0) begin
            r_v0 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go0) begin
            r_mag0 <= w_mag;
            r_neg0 <= w_neg;
        end
    end

    spw_log u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v0),
        .o_ready (w_log_ready),
        .i_mag   (r_mag0),
        .i_neg   (r_neg0),
        .i_drive (r_drive_gain),
        .o_valid (w_log_valid),
        .i_ready (w_exp_ready),
        .o_lg    (w_lg),
        .o_side  (w_side)
    );

    spw_exp u_exp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_log_valid),
        .o_ready  (w_exp_ready),
        .i_lg     (w_lg),
        .i_side   (w_side),
        .i_expo   (r_shape_exponent),
        .o_valid  (o_out_valid),
        .i_ready  (!i_out_stall),
        .o_sample (o_sample_out)
    );

endmodule

`default_nettype wire

// ----- design/spw_checker.sv -----
// Port-level checks of the signed power waveshaper, bound to the top level.
// Depends on spw_pkg and the assertion macros in signed_power_waveshaper_macros.svh.
`default_nettype none
`include "signed_power_waveshaper_macros.svh"

module spw_checker (
    input wire logic                                    i_clk,
    input wire logic                                    i_rst_n,
    input wire logic                                    o_in_stall,
    input wire logic                                    o_out_valid,
    input wire logic                                    i_out_stall,
    input wire logic signed [spw_pkg::OUT_W-1:0]        o_sample_out
);

    localparam logic [spw_pkg::OUT_W-1:0] NEG_FULL = {1'b1, {(spw_pkg::OUT_W - 1){1'b0}}};

    // A stalled result stays on the port unchanged.
    `SPW_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_sample_out), "stalled result changed")

    // Saturation is symmetric, so the most negative code never appears.
    `SPW_ASSERT_IMP(a_no_neg_full, i_clk, i_rst_n, o_out_valid, o_sample_out != NEG_FULL, "result reached the most negative code")

    // The input is held back only when the output is backed up.
    `SPW_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall, "input stalled while output is free")

    // Reset empties the pipeline.
    `SPW_ASSERT_ALWAYS_NXT(a_reset_empty, i_clk, !i_rst_n, !o_out_valid, "result shown right after reset")

endmodule

bind signed_power_waveshaper spw_checker u_spw_checker (.*);

`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for signed_power_waveshaper: a scripted opening run, then
// random requests under several register settings, checked against a local predictor or typed-in results.
// Depends on spw_pkg and the RTL top level only.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spw_pkg::*;

    localparam int LUT_BITS       = TABLE_INDEX_BITS;
    localparam int LUT_LEN        = (1 << LUT_BITS) + 1;
    localparam int LOG_ZERO_BIT   = SAMPLE_WIDTH + 11;
    localparam int OUT_LIMIT      = (1 << (OUT_W - 1)) - 1;
    localparam int ZERO_EXP_SUBST = 328;
    localparam int SETTLE_CYCLES  = 16;
    localparam int TAIL_CYCLES    = 40;
    localparam int QUIET_LIMIT    = 2000;
    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 108;
    localparam int SCRIPT_LEN     = 31;
    localparam int MAX_REPORTS    = 10;

    // Register indexes that map to nothing; writes there must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

    typedef enum logic {ROW_SAMPLE, ROW_REG_WRITE} t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [15:0]            value;
        logic                   typed;
        logic [OUT_W-1:0]       result;
    } t_script_row;

    logic                           i_clk        = 1'b0;
    logic                           i_rst_n      = 1'b0;
    logic                           i_in_valid   = 1'b0;
    logic signed [SAMPLE_WIDTH-1:0] i_sample_in  = '0;
    logic                           i_out_stall  = 1'b0;
    logic                           i_cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0]           i_cfg_index  = '0;
    logic [CFG_DAT_W-1:0]           i_cfg_data   = '0;
    logic                           o_in_stall;
    logic                           o_out_valid;
    logic signed [OUT_W-1:0]        o_sample_out;
    logic                           o_cfg_ready;

    logic [16:0]      log2_lut [LUT_LEN];
    logic [31:0]      exp2_lut [LUT_LEN];
    logic [15:0]      current_gain = 16'd4096;
    logic [15:0]      current_expo = 16'd0;
    logic [OUT_W-1:0] expected_shaped [$];
    int unsigned      error_count = 0;

    t_script_row script [SCRIPT_LEN] = '{
        '{ROW_SAMPLE,    REG_DRIVE_GAIN,     16'h0000, 1'b1, 20'h00000},
        '{ROW_SAMPLE,    REG_DRIVE_GAIN,     16'h7FFF, 1'b0, 20'h00000},
        '{ROW_SAMPLE,    REG_DRIVE_GAIN,     16'h8000, 1'b0, 20'h00000},
        '{ROW_SAMPLE,    REG_DRIVE_GAIN,     16'h0001, 1'b0, 20'h00000},
        '{ROW_SAMPLE,    REG_DRIVE_GAIN,     16'hFFFF, 1'b0, 20'h00000},
        '{ROW_REG_WRITE, REG_SPARE_2,        16'h0000, 1'b0, 20'h00000},
        '{ROW_REG_WRITE, REG_SPARE_3,        16'hFFFF, 1'b0, 20'h00000},
        '{ROW_SAMPLE,    REG_DRIVE_GAIN,     16'h4000, 1'b0, 20'h00000},
        '{ROW_REG_WRITE, REG_SHAPE_EXPONENT, 16'h8000, 1'b0, 20'h00000},
        '{ROW_SAMPLE,    REG_DRIVE_GAIN,     16'h4000, 1'b1, 20'h04000},
        '{ROW_SAMPLE,    REG_DRIVE_GAIN,     16'hC000, 1'b1, 20'hFC000},
        '{ROW_SAMPLE,    REG_DRIVE_GAIN,     16'h8000, 1'b1, 20'hF8000},
        '{ROW_SAMPLE,    REG_DRIVE_GAIN,     16'h0000, 1'b1, 20'h00000},
        '{ROW_SAMPLE,    REG_DRIVE_GAIN,     16'h3039, 1'b0, 20'h00000},
        '{ROW_REG_WRITE, REG_DRIVE_GAIN,     16'h0000, 1'b0, 20'h00000},
        '{ROW_SAMPLE,    REG_DRIVE_GAIN,     16'h7FFF, 1'b1, 20'h00000},
        '{ROW_SAMPLE,    REG_DRIVE_GAIN,     16'h8000, 1'b1, 20'h00000},
        '{ROW_REG_WRITE, REG_DRIVE_GAIN,     16'hFFFF, 1'b0, 20'h00000},
        '{ROW_REG_WRITE, REG_SHAPE_EXPONENT, 16'hFFFF, 1'b0, 20'h00000},
        '{ROW_SAMPLE,    REG_DRIVE_GAIN,     16'h7FFF, 1'b1, 20'h7FFFF},
        '{ROW_SAMPLE,    REG_DRIVE_GAIN,     16'h8000, 1'b1, 20'h80001},
        '{ROW_SAMPLE,    REG_DRIVE_GAIN,     16'hFFFF, 1'b0, 20'h00000},
        '{ROW_REG_WRITE, REG_DRIVE_GAIN,     16'h0001, 1'b0, 20'h00000},
        '{ROW_SAMPLE,    REG_DRIVE_GAIN,     16'h0001, 1'b1, 20'h00000},
        '{ROW_SAMPLE,    REG_DRIVE_GAIN,     16'hFFFF, 1'b1, 20'h00000},
        '{ROW_SAMPLE,    REG_DRIVE_GAIN,     16'h7FFF, 1'b0, 20'h00000},
        '{ROW_REG_WRITE, REG_SHAPE_EXPONENT, 16'h0000, 1'b0, 20'h00000},
        '{ROW_SAMPLE,    REG_DRIVE_GAIN,     16'h7FFF, 1'b0, 20'h00000},
        '{ROW_SAMPLE,    REG_DRIVE_GAIN,     16'h8000, 1'b0, 20'h00000},
        '{ROW_REG_WRITE, REG_SHAPE_EXPONENT, 16'h0001, 1'b0, 20'h00000},
        '{ROW_SAMPLE,    REG_DRIVE_GAIN,     16'h1388, 1'b0, 20'h00000}
    };

    signed_power_waveshaper dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sample_out (o_sample_out),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    // log2(1 + i/2^LUT_BITS) with 16 fraction bits: each squaring yields one result bit.
    function automatic void build_log2_lut();
        longint unsigned y;
        longint unsigned r;
        for (int i = 0; i < LUT_LEN - 1; i++) begin
            y = longint'((1 << LUT_BITS) + i) << (30 - LUT_BITS);
            r = 0;
            for (int k = 0; k < 17; k++) begin
                y = (y * y) >> 30;
                r = r << 1;
                if (y >= (64'd1 << 31)) begin
                    r = r | 64'd1;
                    y = y >> 1;
                end
            end
            log2_lut[i] = 17'((r + 1) >> 1);
        end
        log2_lut[LUT_LEN-1] = 17'd65536;
    endfunction

    // 2^(i/2^LUT_BITS) in Q2.30, a product of repeated square roots of two.
    function automatic void build_exp2_lut();
        longint unsigned root [LUT_BITS+1];
        longint unsigned acc;
        root[0] = 64'd1 << 31;
        for (int k = 1; k <= LUT_BITS; k++) root[k] = floor_sqrt(root[k-1] << 30);
        for (int i = 0; i < LUT_LEN - 1; i++) begin
            acc = 64'd1 << 30;
            for (int b = 0; b < LUT_BITS; b++) begin
                if (((i >> b) & 1) != 0) acc = (acc * root[LUT_BITS-b] + (64'd1 << 29)) >> 30;
            end
            exp2_lut[i] = 32'(acc);
        end
        exp2_lut[LUT_LEN-1] = 32'h8000_0000;
    endfunction

    function automatic logic [OUT_W-1:0] shape_sample(input logic [SAMPLE_WIDTH-1:0] s,
                                                      input logic [15:0] gain,
                                                      input logic [15:0] expo);
        logic            neg;
        longint unsigned mag;
        longint unsigned prod;
        longint unsigned mant;
        longint unsigned frac;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned t16b;
        longint unsigned g;
        longint unsigned q;
        longint          ex;
        longint          lg;
        longint          n;
        int              idx;
        int              msb;
        int              sh;
        neg  = s[SAMPLE_WIDTH-1];
        mag  = 64'(s);
        if (neg) mag = (64'd1 << SAMPLE_WIDTH) - mag;
        prod = mag * 64'(gain);
        q    = 0;
        if (prod != 0) begin
            ex  = (expo == 16'd0) ? longint'(ZERO_EXP_SUBST) : longint'(expo);
            msb = 63;
            while (prod[msb] == 1'b0) msb--;
            mant = (msb >= 30) ? (prod >> (msb - 30)) : (prod << (30 - msb));
            mant = mant - (64'd1 << 30);
            idx  = int'(mant >> (30 - LUT_BITS));
            frac = mant & ((64'd1 << (30 - LUT_BITS)) - 1);
            lo   = 64'(log2_lut[idx]);
            hi   = 64'(log2_lut[idx+1]);
            lg   = longint'(msb - LOG_ZERO_BIT) * 65536 + longint'(lo)
                 + longint'(((hi - lo) * frac) >> (30 - LUT_BITS));
            // A bias of 256.0 keeps the floored product positive.
            t16b = $unsigned(lg * ex + (64'sd1 <<< 39)) >> 15;
            n    = longint'(t16b >> 16) - 256;
            frac = t16b & 64'hFFFF;
            idx  = int'(frac >> (16 - LUT_BITS));
            frac = frac & ((64'd1 << (16 - LUT_BITS)) - 1);
            lo   = 64'(exp2_lut[idx]);
            hi   = 64'(exp2_lut[idx+1]);
            g    = lo + (((hi - lo) * frac) >> (16 - LUT_BITS));
            if (n >= 15) begin
                q = OUT_LIMIT;
            end else begin
                sh = int'(15 - n);
                if (sh > 40) q = 0;
                else q = (g + (64'd1 << (sh - 1))) >> sh;
            end
            if (q > OUT_LIMIT) q = OUT_LIMIT;
        end
        return neg ? OUT_W'(64'd0 - q) : OUT_W'(q);
    endfunction

    function automatic logic [15:0] pick_sample();
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: v = 16'h0000;
                    1: v = 16'h0001;
                    2: v = 16'hFFFF;
                    3: v = 16'h7FFF;
                    default: v = 16'h8000;
                endcase
            end
            1: v = 16'($urandom_range(0, 64));
            2: v = 16'h1 << $urandom_range(0, 15);
            default: v = 16'($urandom);
        endcase
        if ($urandom_range(0, 1) == 1 && v != 16'h8000) v = -v;
        return v;
    endfunction

    task automatic flag_error(input string what);
        error_count++;
        if (error_count <= MAX_REPORTS) $display("%s", what);
    endtask

    // Holds the request until it is taken, then records what it should produce.
    task automatic offer_sample(input logic [15:0] s, input logic typed,
                                input logic [OUT_W-1:0] typed_result);
        i_in_valid  <= 1'b1;
        i_sample_in <= s;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (typed) expected_shaped.push_back(typed_result);
        else expected_shaped.push_back(shape_sample(s, current_gain, current_expo));
    endtask

    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_shaped.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_DRIVE_GAIN:     current_gain = val;
            REG_SHAPE_EXPONENT: current_expo = val;
            default: ;
        endcase
    endtask

    // Result side: check every taken result, and stall in modes that change now and then.
    int unsigned stall_mode = 0;
    int unsigned mode_left  = 0;
    int unsigned cycle_no   = 0;

    always @(posedge i_clk) begin
        logic [OUT_W-1:0] want;
        cycle_no++;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_shaped.size() == 0) begin
                flag_error($sformatf("unexpected result %05h at %0t", o_sample_out, $realtime));
            end else begin
                want = expected_shaped.pop_front();
                if (o_sample_out !== want) begin
                    flag_error($sformatf("sample_out mismatch at %0t: expected %05h, got %05h",
                                         $realtime, want, o_sample_out));
                end
            end
        end
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 300);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= ($urandom_range(0, 9) < 6);
            default: i_out_stall <= ((cycle_no % 7) < 3);
        endcase
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        int          burst_left;
        int          gap;
        int          pause_at;
        logic [15:0] gain_pick;
        logic [15:0] expo_pick;
        build_log2_lut();
        build_exp2_lut();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < SCRIPT_LEN; r++) begin
            if (script[r].kind == ROW_REG_WRITE) begin
                wait_for_drain();
                write_register(script[r].reg_idx, script[r].value);
            end else begin
                offer_sample(script[r].value, script[r].typed, script[r].result);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(0, 7))
                0: gain_pick = 16'd0;
                1: gain_pick = 16'hFFFF;
                2: gain_pick = 16'd4096;
                3: gain_pick = 16'd1;
                4: gain_pick = 16'($urandom_range(2048, 8192));
                default: gain_pick = 16'($urandom_range(0, 65535));
            endcase
            case ($urandom_range(0, 7))
                0: expo_pick = 16'd0;
                1: expo_pick = 16'd1;
                2: expo_pick = 16'd32768;
                3: expo_pick = 16'hFFFF;
                4: expo_pick = 16'($urandom_range(32769, 65535));
                default: expo_pick = 16'($urandom_range(0, 32768));
            endcase
            wait_for_drain();
            write_register(REG_DRIVE_GAIN, gain_pick);
            wait_for_drain();
            write_register(REG_SHAPE_EXPONENT, expo_pick);

            burst_left = 0;
            pause_at   = $urandom_range(10, PHASE_ITEMS - 10);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k == pause_at) begin
                    wait_for_drain();
                end else if (burst_left <= 0) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4: gap = 0;
                        5, 6, 7: gap = $urandom_range(1, 3);
                        8: gap = $urandom_range(4, 20);
                        default: gap = 1;
                    endcase
                    if (gap != 0) begin
                        i_in_valid <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                             : $urandom_range(1, 12);
                end
                offer_sample(pick_sample(), 1'b0, '0);
                burst_left--;
            end
        end

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_shaped.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
